@@ src/mts_pkg.sv @@
package mts_pkg;

	// command codes carried in s_tuser
	localparam logic [2:0] CMD_TICK   = 3'd0;
	localparam logic [2:0] CMD_START  = 3'd1;
	localparam logic [2:0] CMD_PAUSE  = 3'd2;
	localparam logic [2:0] CMD_RESUME = 3'd3;
	localparam logic [2:0] CMD_STOP   = 3'd4;
	localparam logic [2:0] CMD_LOAD   = 3'd5;

	// play modes
	localparam logic [1:0] MODE_STOPPED = 2'd0;
	localparam logic [1:0] MODE_PLAYING = 2'd1;
	localparam logic [1:0] MODE_PAUSED  = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_FIRST_ENTRY = 2'd0;
	localparam logic [1:0] CFG_REST_CODE   = 2'd1;
	localparam logic [1:0] CFG_TIMER_CLOCK = 2'd2;
	localparam logic [1:0] CFG_GAP_TICKS   = 2'd3;

	localparam logic [15:0] END_MARK      = 16'hFFFF;
	localparam logic [23:0] TCLK_RESET    = 24'd1000000;
	localparam logic [3:0]  GAP_RESET     = 4'd5;

	localparam int CFG_DATA_W = 24;
	localparam int CFG_IDX_W  = 2;
	localparam int S_TDATA_W  = 40;
	localparam int S_TUSER_W  = 3;
	localparam int M_TDATA_W  = 48;

	// period divider: 24-bit dividend, 16-bit divisor
	localparam int DVD_W = 24;
	localparam int DSR_W = 16;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DSR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quot;
	} div_res_t;

endpackage

@@ src/mts_div.sv @@
module mts_div (
	input  logic                clk,
	input  logic                arst_n,
	input  mts_pkg::div_req_t   req,
	output mts_pkg::div_res_t   res
);
	import mts_pkg::*;

	logic                     busy_q;
	logic                     done_q;
	logic [$clog2(DVD_W)-1:0] cnt_q;
	logic [DSR_W-1:0]         rem_q;
	logic [DVD_W-1:0]         quo_q;
	logic [DSR_W-1:0]         dsr_q;
	logic [DSR_W:0]           rem_sh;
	logic                     ge;

	// one quotient bit per cycle, restoring
	assign rem_sh = {rem_q, quo_q[DVD_W-1]};
	assign ge     = rem_sh >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ($clog2(DVD_W))'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? DSR_W'(rem_sh - {1'b0, dsr_q}) : rem_sh[DSR_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

	assign res.done = done_q;
	assign res.quot = quo_q;

endmodule

@@ src/melody_tone_sequencer.sv @@
// melody tone sequencer: note store plus 50 percent duty tone pwm settings
// input channel s_*: one item per command; s_tuser holds the command, s_tdata
// the load fields (entry index, frequency, duration). output channel m_*: exactly
// one result item per input item, in order; m_tlast marks the item that hit the
// song end marker. cfg_we/cfg_index/cfg_data write the four settings registers
// at any edge with cfg_we high.
// work per item: pause, stop, load and idle ticks go straight to the result;
// a tick while playing reads the note store (registered read) and checks the
// elapsed time, and may move on to the next note or to the end marker; a note
// setup with an audible frequency runs the 24-step serial divider (timer clock
// over frequency), as on an audible start or resume, and a tick that both ends
// a gap and moves to the next audible note runs it twice. one item is in work at
// a time; the next item is taken once the result sits in the output register.
// when the receiver stalls, the result waits in the output register; a further
// item is taken and worked but its result waits until the register frees.
// reset: stopped, position 0, period and compare 0, settings at their defaults;
// the note store is not cleared and must be loaded before it is played.
module melody_tone_sequencer #(
	parameter int STORE_DEPTH = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// entry_index[7:0], entry_freq[23:8], entry_duration[39:24]
	input  logic [mts_pkg::S_TDATA_W-1:0]    s_tdata,
	// cmd[2:0]
	input  logic [mts_pkg::S_TUSER_W-1:0]    s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// tone_on[0], reload_value[16:1], compare_value[32:17], play_state[34:33],
	// note_offset[42:35], zero fill above
	output logic [mts_pkg::M_TDATA_W-1:0]    m_tdata,
	// song_ended
	output logic                             m_tlast,
	input  logic                             cfg_we,
	input  logic [mts_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mts_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import mts_pkg::*;

	localparam int AW = $clog2(STORE_DEPTH);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD   = 3'd1;
	localparam logic [2:0] S_CHK  = 3'd2;
	localparam logic [2:0] S_ADV  = 3'd3;
	localparam logic [2:0] S_PC   = 3'd4;
	localparam logic [2:0] S_DIV  = 3'd5;
	localparam logic [2:0] S_EMIT = 3'd6;

	localparam logic [1:0] K_TICK   = 2'd0;
	localparam logic [1:0] K_NEXT   = 2'd1;
	localparam logic [1:0] K_RESUME = 2'd2;

	localparam logic RET_ADV  = 1'b0;
	localparam logic RET_EMIT = 1'b1;

	// settings
	logic [7:0]  fe_q;
	logic [15:0] rest_q;
	logic [23:0] tclk_q;
	logic [3:0]  gapt_q;

	// player state
	logic [2:0]  st_q;
	logic [1:0]  kind_q;
	logic        ret_q;
	logic [1:0]  mode_q;
	logic [7:0]  pos_q;
	logic [15:0] elapsed_q;
	logic [3:0]  gap_q;
	logic [15:0] period_q;
	logic [15:0] compare_q;
	logic        sound_q;
	logic        ended_q;
	logic [15:0] f_q;
	logic [15:0] d_q;

	// output register
	logic                 m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;
	logic                 m_tlast_q;
	logic                 emit_go;

	// note store: {freq, duration}
	logic [31:0]   mem [STORE_DEPTH];
	logic [31:0]   rd_q;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic          mem_we;

	logic          in_acc;
	logic [2:0]    cmd;
	logic [15:0]   rd_freq;
	logic [15:0]   rd_dur;
	logic          f_silent;
	logic [15:0]   new_period;
	div_req_t      div_req;
	div_res_t      div_res;

	// value mod STORE_DEPTH for values below 32 * STORE_DEPTH, by shifted compare and subtract
	function automatic logic [AW-1:0] wrap_addr(input logic [8:0] v);
		logic [31:0] r;
		logic [31:0] lim;
		r = 32'(v);
		for (int k = 4; k >= 0; k--) begin
			lim = 32'(STORE_DEPTH) << k;
			if (r >= lim) begin
				r = r - lim;
			end
		end
		return AW'(r);
	endfunction

	assign in_acc  = s_tvalid && s_tready;
	assign cmd     = s_tuser[2:0];
	assign rd_addr = wrap_addr(9'(fe_q) + 9'(pos_q));
	assign wr_addr = wrap_addr(9'(s_tdata[7:0]));
	assign mem_we  = in_acc && (cmd == CMD_LOAD);
	assign rd_freq = rd_q[31:16];
	assign rd_dur  = rd_q[15:0];
	assign emit_go = (st_q == S_EMIT) && (!m_tvalid_q || m_tready);

	assign f_silent = (f_q == 16'd0) || (f_q == rest_q);

	assign div_req.start    = (st_q == S_PC) && !f_silent;
	assign div_req.dividend = tclk_q;
	assign div_req.divisor  = f_q;

	// period = quotient - 1, zero stays zero, saturate at 16 bits
	always_comb begin
		if (div_res.quot == '0) begin
			new_period = 16'd0;
		end else if (div_res.quot > 24'd65536) begin
			new_period = 16'hFFFF;
		end else begin
			new_period = 16'(div_res.quot - 24'd1);
		end
	end

	mts_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.res    (div_res)
	);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= {s_tdata[23:8], s_tdata[39:24]};
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fe_q   <= 8'd0;
			rest_q <= 16'd0;
			tclk_q <= TCLK_RESET;
			gapt_q <= GAP_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FIRST_ENTRY: fe_q   <= cfg_data[7:0];
				CFG_REST_CODE:   rest_q <= cfg_data[15:0];
				CFG_TIMER_CLOCK: tclk_q <= cfg_data[23:0];
				CFG_GAP_TICKS:   gapt_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= S_IDLE;
			kind_q     <= K_TICK;
			ret_q      <= RET_EMIT;
			mode_q     <= MODE_STOPPED;
			pos_q      <= 8'd0;
			elapsed_q  <= 16'd0;
			gap_q      <= 4'd0;
			period_q   <= 16'd0;
			compare_q  <= 16'd0;
			sound_q    <= 1'b0;
			ended_q    <= 1'b0;
			f_q        <= 16'd0;
			d_q        <= 16'd0;
			m_tvalid_q <= 1'b0;
			m_tlast_q  <= 1'b0;
		end else begin
			if (emit_go) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (st_q)
				S_IDLE: begin
					if (in_acc) begin
						ended_q <= 1'b0;
						st_q    <= S_EMIT;
						case (cmd)
							CMD_TICK: begin
								if (mode_q == MODE_PLAYING) begin
									kind_q <= K_TICK;
									st_q   <= S_RD;
								end
							end
							CMD_START: begin
								mode_q    <= MODE_PLAYING;
								pos_q     <= 8'd0;
								elapsed_q <= 16'd0;
								gap_q     <= 4'd0;
								kind_q    <= K_NEXT;
								st_q      <= S_RD;
							end
							CMD_PAUSE: begin
								if (mode_q == MODE_PLAYING) begin
									mode_q    <= MODE_PAUSED;
									compare_q <= 16'd0;
									sound_q   <= 1'b0;
								end
							end
							CMD_RESUME: begin
								if (mode_q == MODE_PAUSED) begin
									mode_q <= MODE_PLAYING;
									kind_q <= K_RESUME;
									st_q   <= S_RD;
								end
							end
							CMD_STOP: begin
								mode_q    <= MODE_STOPPED;
								compare_q <= 16'd0;
								sound_q   <= 1'b0;
								pos_q     <= 8'd0;
								elapsed_q <= 16'd0;
								gap_q     <= 4'd0;
							end
							default: ;
						endcase
					end
				end
				S_RD: begin
					st_q <= S_CHK;
				end
				S_CHK: begin
					f_q <= rd_freq;
					case (kind_q)
						K_TICK: begin
							d_q  <= rd_dur;
							st_q <= S_ADV;
							if (elapsed_q != 16'hFFFF) begin
								elapsed_q <= elapsed_q + 16'd1;
							end
							if (gap_q != 4'd0) begin
								gap_q <= gap_q - 4'd1;
								// gap just ran out: set up the current note first
								if (gap_q == 4'd1) begin
									ret_q <= RET_ADV;
									st_q  <= S_PC;
								end
							end
						end
						K_NEXT: begin
							if (rd_freq == END_MARK) begin
								mode_q    <= MODE_STOPPED;
								compare_q <= 16'd0;
								sound_q   <= 1'b0;
								pos_q     <= 8'd0;
								elapsed_q <= 16'd0;
								gap_q     <= 4'd0;
								ended_q   <= 1'b1;
								st_q      <= S_EMIT;
							end else begin
								ret_q <= RET_EMIT;
								st_q  <= S_PC;
							end
						end
						default: begin
							ret_q <= RET_EMIT;
							st_q  <= S_PC;
						end
					endcase
				end
				S_ADV: begin
					if (elapsed_q >= d_q) begin
						compare_q <= 16'd0;
						sound_q   <= 1'b0;
						pos_q     <= pos_q + 8'd1;
						elapsed_q <= 16'd0;
						gap_q     <= gapt_q;
						kind_q    <= K_NEXT;
						st_q      <= S_RD;
					end else begin
						st_q <= S_EMIT;
					end
				end
				S_PC: begin
					if (f_silent) begin
						compare_q <= 16'd0;
						sound_q   <= 1'b0;
						st_q      <= (ret_q == RET_EMIT) ? S_EMIT : S_ADV;
					end else begin
						st_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_res.done) begin
						period_q <= new_period;
						if (gap_q == 4'd0) begin
							compare_q <= new_period >> 1;
							sound_q   <= 1'b1;
						end else begin
							compare_q <= 16'd0;
							sound_q   <= 1'b0;
						end
						st_q <= (ret_q == RET_EMIT) ? S_EMIT : S_ADV;
					end
				end
				S_EMIT: begin
					if (emit_go) begin
						m_tlast_q <= ended_q;
						st_q      <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			m_tdata_q <= {5'd0, pos_q, mode_q, compare_q, period_q, sound_q};
		end
	end

	assign s_tready = (st_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	a_tone_needs_play: assert property (@(posedge clk) disable iff (!arst_n)
		sound_q |-> (mode_q == MODE_PLAYING))
		else $error("tone sounding outside playing mode");

	a_tone_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		sound_q |-> (gap_q == 4'd0))
		else $error("tone sounding while a gap is running");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> (st_q == S_DIV))
		else $error("divider finished outside the divide state");

	a_end_stops: assert property (@(posedge clk) disable iff (!arst_n)
		ended_q |-> (mode_q == MODE_STOPPED))
		else $error("song end reported while not stopped");

	a_div_start_once: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |=> (st_q == S_DIV) && !div_req.start)
		else $error("divider restarted while busy");

endmodule

@@ dv/testbench.sv @@
module testbench;
	import mts_pkg::*;

	localparam logic [2:0] CMD_SPARE_A = 3'd6;
	localparam logic [2:0] CMD_SPARE_B = 3'd7;
	localparam int RANDOM_ITEMS = 950;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int STALL_HOLD   = 400;

	typedef struct packed {
		logic        tone;
		logic [15:0] reload;
		logic [15:0] compare;
		logic [1:0]  state;
		logic [7:0]  offset;
		logic        ended;
	} tone_res_t;

	localparam tone_res_t ZERO_RES = '{tone: 1'b0, reload: 16'd0, compare: 16'd0,
		state: MODE_STOPPED, offset: 8'd0, ended: 1'b0};

	typedef enum bit {ROW_ITEM, ROW_SETTING} row_kind_e;

	typedef struct {
		row_kind_e   kind;
		logic [2:0]  cmd;
		logic [7:0]  idx;
		logic [15:0] freq;
		logic [15:0] dur;
		bit          typed;
		tone_res_t   want;
		logic [1:0]  sel;
		logic [23:0] value;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [S_TUSER_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic m_tlast;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// player state as the predictor sees it
	logic [15:0] note_freq [256];
	logic [15:0] note_len [256];
	logic [1:0]  p_mode = MODE_STOPPED;
	logic [7:0]  p_pos = '0;
	logic [15:0] p_elapsed = '0;
	logic [3:0]  p_gap = '0;
	logic [15:0] p_period = '0;
	logic [15:0] p_compare = '0;
	logic        p_sound = 1'b0;
	logic [7:0]  c_first = '0;
	logic [15:0] c_rest = '0;
	logic [23:0] c_tclk = TCLK_RESET;
	logic [3:0]  c_gap = GAP_RESET;

	tone_res_t expected_tones [$];
	row_t script [$];
	int fails = 0;
	int cycles = 0;
	int items_sent = 0;
	int burst_left = 0;
	bit hold_req = 1'b0;

	melody_tone_sequencer dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [7:0] note_addr();
		return c_first + p_pos;
	endfunction

	function automatic bit is_quiet(logic [15:0] f);
		return f == 16'd0 || f == c_rest;
	endfunction

	// program the tone for the current note; stays muted while the gap runs
	function automatic void setup_note();
		logic [15:0] f;
		logic [23:0] q;
		logic [23:0] per;
		f = note_freq[note_addr()];
		if (is_quiet(f) || p_gap != 4'd0) begin
			p_compare = 16'd0;
			p_sound = 1'b0;
		end
		if (!is_quiet(f)) begin
			q = c_tclk / f;
			per = (q == 24'd0) ? 24'd0 : q - 24'd1;
			if (per > 24'hFFFF)
				per = 24'hFFFF;
			p_period = per[15:0];
			if (p_gap == 4'd0) begin
				p_compare = p_period >> 1;
				p_sound = 1'b1;
			end
		end
	endfunction

	function automatic void halt_song();
		p_mode = MODE_STOPPED;
		p_compare = 16'd0;
		p_sound = 1'b0;
		p_pos = 8'd0;
		p_elapsed = 16'd0;
		p_gap = 4'd0;
	endfunction

	function automatic tone_res_t play_item(logic [2:0] c, logic [7:0] idx, logic [15:0] f,
			logic [15:0] d);
		logic ended;
		ended = 1'b0;
		case (c)
			CMD_TICK: begin
				if (p_mode == MODE_PLAYING) begin
					if (p_elapsed != 16'hFFFF)
						p_elapsed++;
					if (p_gap != 4'd0) begin
						p_gap--;
						if (p_gap == 4'd0)
							setup_note();
					end
					if (p_elapsed >= note_len[note_addr()]) begin
						p_compare = 16'd0;
						p_sound = 1'b0;
						p_pos++;
						if (note_freq[note_addr()] == END_MARK) begin
							halt_song();
							ended = 1'b1;
						end else begin
							p_elapsed = 16'd0;
							p_gap = c_gap;
							setup_note();
						end
					end
				end
			end
			CMD_START: begin
				p_mode = MODE_PLAYING;
				p_pos = 8'd0;
				p_elapsed = 16'd0;
				p_gap = 4'd0;
				if (note_freq[note_addr()] == END_MARK) begin
					halt_song();
					ended = 1'b1;
				end else begin
					setup_note();
				end
			end
			CMD_PAUSE: begin
				if (p_mode == MODE_PLAYING) begin
					p_mode = MODE_PAUSED;
					p_compare = 16'd0;
					p_sound = 1'b0;
				end
			end
			CMD_RESUME: begin
				if (p_mode == MODE_PAUSED) begin
					p_mode = MODE_PLAYING;
					setup_note();
				end
			end
			CMD_STOP: halt_song();
			CMD_LOAD: begin
				note_freq[idx] = f;
				note_len[idx] = d;
			end
			default: ;
		endcase
		return '{tone: p_sound, reload: p_period, compare: p_compare, state: p_mode,
			offset: p_pos, ended: ended};
	endfunction

	function automatic logic [15:0] pick_freq();
		case ($urandom_range(0, 11))
			0: return 16'd0;
			1: return c_rest;
			2: return 16'd1;
			3: return 16'hFFFE;
			4: return 16'($urandom);
			5: return 16'($urandom_range(2, 100));
			default: return 16'($urandom_range(100, 8000));
		endcase
	endfunction

	function automatic logic [15:0] pick_len();
		case ($urandom_range(0, 9))
			0: return 16'hFFFF;
			1: return 16'($urandom);
			default: return 16'($urandom_range(0, 6));
		endcase
	endfunction

	function automatic void plan_item(logic [2:0] c, logic [7:0] idx, logic [15:0] f,
			logic [15:0] d);
		row_t r;
		r = '{kind: ROW_ITEM, cmd: c, idx: idx, freq: f, dur: d, typed: 1'b0,
			want: ZERO_RES, sel: CFG_FIRST_ENTRY, value: 24'd0};
		script.push_back(r);
	endfunction

	function automatic void plan_checked(logic [2:0] c, logic [7:0] idx, logic [15:0] f,
			logic [15:0] d, tone_res_t want);
		row_t r;
		r = '{kind: ROW_ITEM, cmd: c, idx: idx, freq: f, dur: d, typed: 1'b1,
			want: want, sel: CFG_FIRST_ENTRY, value: 24'd0};
		script.push_back(r);
	endfunction

	function automatic void plan_setting(logic [1:0] sel, logic [23:0] value);
		row_t r;
		r = '{kind: ROW_SETTING, cmd: CMD_TICK, idx: 8'd0, freq: 16'd0, dur: 16'd0,
			typed: 1'b0, want: ZERO_RES, sel: sel, value: value};
		script.push_back(r);
	endfunction

	// sender in bursts; the expectation is queued when the item is taken
	task automatic send_item(input logic [2:0] c, input logic [7:0] idx,
			input logic [15:0] f, input logic [15:0] d, input bit typed,
			input tone_res_t want);
		tone_res_t predicted;
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			repeat (gap) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= c;
		s_tdata <= {d, f, idx};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predicted = play_item(c, idx, f, d);
		expected_tones.push_back(typed ? want : predicted);
		items_sent++;
	endtask

	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_tones.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_register(input logic [1:0] sel, input logic [23:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= sel;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (sel)
			CFG_FIRST_ENTRY: c_first = value[7:0];
			CFG_REST_CODE:   c_rest = value[15:0];
			CFG_TIMER_CLOCK: c_tclk = value;
			CFG_GAP_TICKS:   c_gap = value[3:0];
			default: ;
		endcase
	endtask

	function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
			fails++;
		end
	endfunction

	always @(posedge clk) begin : result_check
		tone_res_t got;
		tone_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{tone: m_tdata[0], reload: m_tdata[16:1], compare: m_tdata[32:17],
				state: m_tdata[34:33], offset: m_tdata[42:35], ended: m_tlast};
			if (expected_tones.size() == 0) begin
				$display("%0t: unexpected result item %h last %b", $time, m_tdata, m_tlast);
				fails++;
			end else begin
				want = expected_tones.pop_front();
				compare_field("tone_on", 16'(want.tone), 16'(got.tone));
				compare_field("reload_value", want.reload, got.reload);
				compare_field("compare_value", want.compare, got.compare);
				compare_field("play_state", 16'(want.state), 16'(got.state));
				compare_field("note_offset", 16'(want.offset), 16'(got.offset));
				compare_field("song_ended", 16'(want.ended), 16'(got.ended));
				compare_field("fill", 16'd0, 16'(m_tdata[M_TDATA_W-1:43]));
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// receiver: changing stall styles, plus one long hold-off on request
	initial begin : receiver
		int style;
		int span;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				repeat (STALL_HOLD) begin
					@(negedge clk);
					m_tready <= 1'b0;
				end
			end
			style = $urandom_range(0, 3);
			span = $urandom_range(20, 150);
			for (int k = 0; k < span; k++) begin
				@(negedge clk);
				case (style)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 1) == 1);
					2: m_tready <= (k % 5) != 4;
					default: m_tready <= (k % 8) < 3;
				endcase
			end
		end
	end

	initial begin : stimulus
		logic [1:0]  sel;
		logic [23:0] val;
		logic [7:0]  song_base;
		int notes;
		int steps;
		int pick;
		int r;

		// short song at 0..3: tone, zero-frequency rest, saturated period, end mark
		plan_checked(CMD_PAUSE, 8'd0, 16'd0, 16'd0, ZERO_RES);
		plan_checked(CMD_RESUME, 8'd0, 16'd0, 16'd0, ZERO_RES);
		plan_checked(CMD_TICK, 8'd0, 16'd0, 16'd0, ZERO_RES);
		plan_checked(CMD_SPARE_A, 8'hFF, 16'hFFFF, 16'hFFFF, ZERO_RES);
		plan_checked(CMD_SPARE_B, 8'd0, 16'd0, 16'd0, ZERO_RES);
		plan_checked(CMD_LOAD, 8'd0, 16'd1000, 16'd2, ZERO_RES);
		plan_checked(CMD_LOAD, 8'd1, 16'd0, 16'd1, ZERO_RES);
		plan_checked(CMD_LOAD, 8'd2, 16'd10, 16'd0, ZERO_RES);
		plan_checked(CMD_LOAD, 8'd3, END_MARK, 16'hFFFF, ZERO_RES);
		plan_checked(CMD_START, 8'd0, 16'd0, 16'd0, '{tone: 1'b1, reload: 16'd999,
			compare: 16'd499, state: MODE_PLAYING, offset: 8'd0, ended: 1'b0});
		plan_item(CMD_TICK, 8'd0, 16'd0, 16'd0);
		plan_item(CMD_PAUSE, 8'd0, 16'd0, 16'd0);
		plan_item(CMD_TICK, 8'd0, 16'd0, 16'd0);
		plan_item(CMD_RESUME, 8'd0, 16'd0, 16'd0);
		plan_item(CMD_TICK, 8'd0, 16'd0, 16'd0);
		plan_item(CMD_TICK, 8'd0, 16'd0, 16'd0);
		plan_item(CMD_TICK, 8'd0, 16'd0, 16'd0);
		plan_item(CMD_START, 8'd0, 16'd0, 16'd0);
		plan_item(CMD_START, 8'd0, 16'd0, 16'd0);
		plan_checked(CMD_STOP, 8'd0, 16'd0, 16'd0, '{tone: 1'b0, reload: 16'd999,
			compare: 16'd0, state: MODE_STOPPED, offset: 8'd0, ended: 1'b0});
		// slowest timer with the highest note: period collapses to zero
		plan_setting(CFG_TIMER_CLOCK, 24'd1000);
		plan_setting(CFG_FIRST_ENTRY, 24'hFF);
		plan_setting(CFG_GAP_TICKS, 24'd0);
		plan_item(CMD_LOAD, 8'hFF, 16'hFFFE, 16'd1);
		plan_checked(CMD_START, 8'd0, 16'd0, 16'd0, '{tone: 1'b1, reload: 16'd0,
			compare: 16'd0, state: MODE_PLAYING, offset: 8'd0, ended: 1'b0});
		plan_item(CMD_TICK, 8'd0, 16'd0, 16'd0);
		// rest code matching a stored note, fastest timer
		plan_setting(CFG_REST_CODE, 24'd1000);
		plan_setting(CFG_TIMER_CLOCK, 24'd16000000);
		plan_item(CMD_START, 8'd0, 16'd0, 16'd0);
		plan_item(CMD_TICK, 8'd0, 16'd0, 16'd0);
		plan_item(CMD_STOP, 8'd0, 16'd0, 16'd0);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (script[i]) begin
			if (script[i].kind == ROW_SETTING) begin
				settle();
				set_register(script[i].sel, script[i].value);
			end else begin
				send_item(script[i].cmd, script[i].idx, script[i].freq, script[i].dur,
					script[i].typed, script[i].want);
			end
		end

		// fill the whole store so that every later read hits a loaded entry
		items_sent = 0;
		hold_req = 1'b1;
		for (int a = 0; a < 256; a++)
			send_item(CMD_LOAD, 8'(a), ($urandom_range(0, 9) == 0) ? END_MARK : pick_freq(),
				pick_len(), 1'b0, ZERO_RES);

		while (items_sent < RANDOM_ITEMS) begin
			settle();
			repeat ($urandom_range(0, 2)) begin
				sel = 2'($urandom_range(CFG_REST_CODE, CFG_GAP_TICKS));
				r = $urandom_range(0, 3);
				case (sel)
					CFG_REST_CODE:
						val = (r == 0) ? 24'd0 : (r == 1) ? 24'hFFFF :
							(r == 2) ? 24'($urandom_range(0, 65535)) :
							24'($urandom_range(100, 8000));
					CFG_TIMER_CLOCK:
						val = (r == 0) ? 24'd1000 : (r == 1) ? 24'd16000000 :
							(r == 2) ? 24'd1000000 : 24'($urandom_range(1000, 16000000));
					default:
						val = (r == 0) ? 24'd0 : (r == 1) ? 24'd15 :
							24'($urandom_range(0, 15));
				endcase
				set_register(sel, val);
			end
			r = $urandom_range(0, 5);
			song_base = (r == 0) ? 8'd0 : (r == 1) ? 8'hFF : 8'($urandom_range(0, 255));
			set_register(CFG_FIRST_ENTRY, 24'(song_base));

			notes = $urandom_range(1, 8);
			for (int n = 0; n < notes; n++)
				send_item(CMD_LOAD, 8'(song_base + 8'(n)), pick_freq(), pick_len(), 1'b0,
					ZERO_RES);
			if ($urandom_range(0, 4) != 0)
				send_item(CMD_LOAD, 8'(song_base + 8'(notes)), END_MARK, 16'($urandom), 1'b0,
					ZERO_RES);
			send_item(CMD_START, 8'($urandom), 16'($urandom), 16'($urandom), 1'b0, ZERO_RES);

			// mostly ticks, with transport commands and stray items mixed in
			steps = $urandom_range(5, 60);
			repeat (steps) begin
				pick = $urandom_range(0, 99);
				if (pick < 78)
					send_item(CMD_TICK, 8'($urandom), 16'($urandom), 16'($urandom), 1'b0,
						ZERO_RES);
				else if (pick < 84)
					send_item(CMD_PAUSE, 8'($urandom), 16'($urandom), 16'($urandom), 1'b0,
						ZERO_RES);
				else if (pick < 90)
					send_item(CMD_RESUME, 8'($urandom), 16'($urandom), 16'($urandom), 1'b0,
						ZERO_RES);
				else if (pick < 92)
					send_item(CMD_STOP, 8'($urandom), 16'($urandom), 16'($urandom), 1'b0,
						ZERO_RES);
				else if (pick < 94)
					send_item(CMD_START, 8'($urandom), 16'($urandom), 16'($urandom), 1'b0,
						ZERO_RES);
				else if (pick < 97)
					send_item(CMD_LOAD, 8'($urandom), pick_freq(), pick_len(), 1'b0, ZERO_RES);
				else
					send_item($urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B, 8'($urandom),
						16'($urandom), 16'($urandom), 1'b0, ZERO_RES);
			end
		end

		settle();
		repeat (100) @(posedge clk);
		if (fails == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
